FILE: hdl/vtk_pkg.sv
// Shared types, constants and key table for the terminal key sequence decoder.
// No dependencies; compiled first.
package vtk_pkg;

  typedef logic [7:0] byte_t;

  localparam int BUF_DEPTH  = 8;
  localparam int FILL_W     = $clog2(BUF_DEPTH + 1);
  localparam int KEY_COUNT  = 22;
  localparam int KEY_MAXLEN = 4;
  localparam int SEQ_IDX_W  = $clog2(KEY_MAXLEN);
  localparam int KEY_W      = 5;
  localparam int KEY_LEN_W  = 3;

  localparam byte_t CH_ESC      = 8'o033;
  localparam byte_t CH_LBRACKET = 8'o133;
  localparam byte_t ESC_FIN_LO  = 8'o060;
  localparam byte_t ESC_FIN_HI  = 8'o177;
  localparam byte_t CSI_FIN_LO  = 8'o100;
  localparam byte_t CSI_FIN_HI  = 8'o176;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2
  } mode_t;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN [KEY_COUNT] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd1
  };

  localparam byte_t KEY_SEQ [KEY_COUNT][KEY_MAXLEN] = '{
    '{8'o033, 8'o133, 8'h41, 8'h00},  // up
    '{8'o033, 8'o133, 8'h42, 8'h00},  // down
    '{8'o033, 8'o133, 8'h43, 8'h00},  // right
    '{8'o033, 8'o133, 8'h44, 8'h00},  // left
    '{8'o177, 8'h00,  8'h00, 8'h00},  // DEL
    '{8'o012, 8'h00,  8'h00, 8'h00},  // LF
    '{8'o001, 8'h00,  8'h00, 8'h00},
    '{8'o005, 8'h00,  8'h00, 8'h00},
    '{8'o013, 8'h00,  8'h00, 8'h00},
    '{8'o031, 8'h00,  8'h00, 8'h00},
    '{8'o003, 8'h00,  8'h00, 8'h00},
    '{8'o006, 8'h00,  8'h00, 8'h00},
    '{8'o002, 8'h00,  8'h00, 8'h00},
    '{8'o033, 8'o133, 8'h33, 8'h7e},  // delete key
    '{8'o011, 8'h00,  8'h00, 8'h00},  // TAB
    '{8'o004, 8'h00,  8'h00, 8'h00},
    '{8'o014, 8'h00,  8'h00, 8'h00},
    '{8'o015, 8'h00,  8'h00, 8'h00},  // CR
    '{8'o033, 8'o177, 8'h00, 8'h00},  // ESC DEL
    '{8'o033, 8'h62,  8'h00, 8'h00},  // word back
    '{8'o033, 8'h66,  8'h00, 8'h00},  // word forward
    '{8'h3f,  8'h00,  8'h00, 8'h00}   // '?'
  };

endpackage

FILE: hdl/vtk_if.sv
// Valid/ready channel interfaces for the key sequence decoder.
// Depends on vtk_pkg for payload widths.
interface vtk_in_if
  import vtk_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t byte_in;
  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface vtk_out_if
  import vtk_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             done_res;
  logic             matched;
  logic [KEY_W-1:0] key_index;
  modport source (output valid, output done_res, output matched, output key_index,
                  input ready);
  modport sink (input valid, input done_res, input matched, input key_index,
                output ready);
endinterface

FILE: hdl/vt100_key_sequence_decoder.sv
// Terminal key sequence decoder: parse state, sequence buffer and table match.
// Depends on vtk_pkg and the channel interfaces in vtk_if.sv.
//
// Usage:
//   in_ch carries one terminal byte per request (byte_in). out_ch returns
//   exactly one result per byte: done_res, matched, key_index.
//   A byte is taken at a clock edge where in_ch.valid and in_ch.ready are high.
//   Its result is held in the output register from that edge on.
//   Throughput is one byte per cycle unless stalled; the parse update and the
//   22-entry table compare are one combinational pass to the result register.
//   in_ch.ready is high whenever the output register is empty or being taken
//   in the same cycle, so a stalled receiver holds the result and stops input
//   only while the result waits; no result is dropped or repeated.
//   Reset (rst_n low, synchronous) returns the parser to idle with an empty
//   buffer and clears the output valid. Sequence bytes are kept only up to
//   the longest key; longer sequences still count toward the buffer limit,
//   after which the next byte restarts parsing from idle.
module vt100_key_sequence_decoder
  import vtk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  vtk_in_if.sink    in_ch,
  vtk_out_if.source out_ch
);

  mode_t             mode_r, mode_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  byte_t             seq_r [KEY_MAXLEN];

  logic              out_valid_r;
  logic              done_r, done_nxt;
  logic              match_r, match_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;

  logic              accept;
  logic              full;
  logic [FILL_W-1:0] fill_eff;
  logic [FILL_W-1:0] seq_size;
  mode_t             mode_eff;
  byte_t             c;
  byte_t             cand [KEY_MAXLEN];

  assign c      = in_ch.byte_in;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;

  // buffer full: restart as the first byte of a new sequence
  assign full     = (fill_r >= FILL_W'(BUF_DEPTH));
  assign fill_eff = full ? '0 : fill_r;
  assign mode_eff = full ? MODE_IDLE : mode_r;
  assign seq_size = fill_eff + FILL_W'(1);

  always_comb begin
    for (int i = 0; i < KEY_MAXLEN; i++) begin
      cand[i] = (FILL_W'(i) == fill_eff) ? c : seq_r[i];
    end
  end

  always_comb begin
    mode_nxt = mode_eff;
    fill_nxt = seq_size;
    done_nxt = 1'b0;
    unique case (mode_eff)
      MODE_IDLE: begin
        if (c == CH_ESC) mode_nxt = MODE_ESC;
        else             done_nxt = 1'b1;
      end
      MODE_ESC: begin
        if (c == CH_LBRACKET)                        mode_nxt = MODE_CSI;
        else if (c >= ESC_FIN_LO && c <= ESC_FIN_HI) done_nxt = 1'b1;
      end
      MODE_CSI: begin
        if (c >= CSI_FIN_LO && c <= CSI_FIN_HI) done_nxt = 1'b1;
      end
      default: fill_nxt = '0;
    endcase
    if (done_nxt) begin
      fill_nxt = '0;
      mode_nxt = MODE_IDLE;
    end
  end

  // exact compare against every entry; lowest index wins
  always_comb begin
    logic same;
    match_nxt = 1'b0;
    key_nxt   = '0;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      same = (FILL_W'(KEY_LEN[k]) == seq_size);
      for (int i = 0; i < KEY_MAXLEN; i++) begin
        if (FILL_W'(i) < seq_size && cand[i] != KEY_SEQ[k][i]) same = 1'b0;
      end
      if (same) begin
        match_nxt = 1'b1;
        key_nxt   = KEY_W'(k);
      end
    end
    if (!done_nxt) begin
      match_nxt = 1'b0;
      key_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r <= mode_nxt;
        fill_r <= fill_nxt;
      end
      if (accept)            out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      done_r  <= done_nxt;
      match_r <= match_nxt;
      key_r   <= key_nxt;
      if (fill_eff < FILL_W'(KEY_MAXLEN)) seq_r[fill_eff[SEQ_IDX_W-1:0]] <= c;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.done_res  = done_r;
  assign out_ch.matched   = match_r;
  assign out_ch.key_index = key_r;

endmodule
